### hdl/glob_pattern_matcher_assert.svh
// ----------------------------------------------------------------------------
// Glob pattern matcher assertion macros
// Concurrent assertion shorthands on clk with synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef GLOB_PATTERN_MATCHER_ASSERT_SVH
`define GLOB_PATTERN_MATCHER_ASSERT_SVH

// same-cycle implication
`define GPM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("glob pattern matcher assertion failed");

// next-cycle implication
`define GPM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("glob pattern matcher assertion failed");

`endif

### hdl/gpm_pkg.sv
// ----------------------------------------------------------------------------
// Glob pattern matcher package
// Word types, cell roles, write-port and wave structs, character constants and case folding.
// ----------------------------------------------------------------------------
package gpm_pkg;

  localparam int IDX_W = 6;

  localparam logic FUNC_PATTERN = 1'b0;

  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_LBR   = 8'h5B;
  localparam logic [7:0] CH_RBR   = 8'h5D;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  typedef enum logic [3:0] {
    ROLE_LIT,
    ROLE_ANY,
    ROLE_STAR,
    ROLE_ESC,
    ROLE_ESCD,
    ROLE_OPEN,
    ROLE_NEG,
    ROLE_ESCB,
    ROLE_SINGLE,
    ROLE_LO,
    ROLE_DASH,
    ROLE_HI,
    ROLE_CLOSE,
    ROLE_END
  } gpm_role_t;

  typedef struct packed {
    logic       func;
    logic [7:0] char_value;
    logic       is_empty;
    logic       last;
  } gpm_in_t;

  typedef struct packed {
    logic match;
    logic pattern_error;
    logic for_pattern;
  } gpm_out_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] widx;
    logic [7:0]       wchar;
    gpm_role_t        wrole;
    logic             fe;
    logic [IDX_W-1:0] fidx;
    logic             clr;
  } gpm_wr_t;

  typedef struct packed {
    logic       vld;
    logic [7:0] ch;
    logic       has_ch;
    logic       last;
    logic       sc;
    logic       sc2;
    logic       tk;
    logic       h;
    logic       neg;
    logic       ge;
    logic       land;
    logic       mt;
  } gpm_wave_t;

  function automatic logic [7:0] fold_char(input logic [7:0] c, input logic en);
    logic [7:0] r;
    r = c;
    if (en && c >= CH_LA && c <= CH_LZ) r = c - CASE_OFS;
    return r;
  endfunction

endpackage

### hdl/gpm_cell.sv
// ----------------------------------------------------------------------------
// Glob pattern matcher cell
// Holds one pattern position and evaluates each passing text word wave.
// ----------------------------------------------------------------------------
module gpm_cell #(
  parameter int IDX = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  gpm_pkg::gpm_wr_t              wr,
  input  logic [gpm_pkg::IDX_W-1:0]     len,
  input  gpm_pkg::gpm_wave_t            wave_i,
  output gpm_pkg::gpm_wave_t            wave_o
);

  localparam logic [gpm_pkg::IDX_W-1:0] IDX_V = gpm_pkg::IDX_W'(IDX);
  localparam logic                      INIT  = (IDX == 0);

  logic [7:0]          char_r;
  gpm_pkg::gpm_role_t  role_r;
  logic                pend_r;
  logic                pend_nxt;
  gpm_pkg::gpm_wave_t  wave_r;
  gpm_pkg::gpm_wave_t  wave_nxt;
  gpm_pkg::gpm_role_t  role_e;
  logic                act;
  logic                star;
  logic                fin;
  logic                eq;
  logic                ge;
  logic                le;

  always_comb begin
    role_e   = (len == IDX_V) ? gpm_pkg::ROLE_END : role_r;
    act      = pend_r | wave_i.sc;
    star     = (role_e == gpm_pkg::ROLE_STAR);
    eq       = (wave_i.ch == char_r);
    ge       = (wave_i.ch >= char_r);
    le       = (wave_i.ch <= char_r);
    wave_nxt = wave_i;
    wave_nxt.sc   = 1'b0;
    wave_nxt.land = 1'b0;
    case (role_e)
      gpm_pkg::ROLE_STAR:   wave_nxt.sc   = act;
      gpm_pkg::ROLE_ANY:    wave_nxt.land = act;
      gpm_pkg::ROLE_LIT:    wave_nxt.land = act & eq;
      gpm_pkg::ROLE_ESC:    wave_nxt.tk   = act;
      gpm_pkg::ROLE_ESCD:   wave_nxt.land = wave_i.tk & eq;
      gpm_pkg::ROLE_OPEN: begin
        wave_nxt.tk  = act;
        wave_nxt.h   = 1'b0;
        wave_nxt.neg = 1'b0;
      end
      gpm_pkg::ROLE_NEG:    wave_nxt.neg  = 1'b1;
      gpm_pkg::ROLE_SINGLE: wave_nxt.h    = wave_i.h | eq;
      gpm_pkg::ROLE_LO:     wave_nxt.ge   = ge;
      gpm_pkg::ROLE_HI:     wave_nxt.h    = wave_i.h | (wave_i.ge & le);
      gpm_pkg::ROLE_CLOSE:  wave_nxt.land = wave_i.tk & (wave_i.h ^ wave_i.neg);
      default: ;
    endcase
    wave_nxt.land = wave_nxt.land & wave_i.has_ch;
    pend_nxt      = wave_i.has_ch ? (wave_i.land | (act & star)) : act;
    fin           = pend_nxt | wave_i.sc2;
    wave_nxt.sc2  = fin & star;
    if (role_e == gpm_pkg::ROLE_END) wave_nxt.mt = fin;
  end

  always_ff @(posedge clk) begin
    if (wr.we && wr.widx == IDX_V) begin
      char_r <= wr.wchar;
      role_r <= wr.wrole;
    end else if (wr.fe && wr.fidx == IDX_V) begin
      role_r <= gpm_pkg::ROLE_LO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= INIT;
      wave_r <= '0;
    end else begin
      if (wr.clr) begin
        pend_r <= INIT;
      end else if (adv && wave_i.vld) begin
        pend_r <= wave_i.last ? INIT : pend_nxt;
      end
      if (adv) begin
        wave_r <= wave_nxt;
      end
    end
  end

  assign wave_o = wave_r;

endmodule

### hdl/gpm_loader.sv
// ----------------------------------------------------------------------------
// Glob pattern matcher loader
// Checks pattern words, assigns cell roles and tracks pattern errors.
// ----------------------------------------------------------------------------
module gpm_loader #(
  parameter int MAX_PATTERN = 63
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      acc,
  input  gpm_pkg::gpm_in_t          in_word,
  input  logic                      match_case,
  output gpm_pkg::gpm_wr_t          wr,
  output logic [gpm_pkg::IDX_W-1:0] len,
  output logic                      err_flag,
  output logic                      err_final,
  output logic                      fold,
  output logic                      load_open
);

  localparam logic [gpm_pkg::IDX_W-1:0] MAXV = gpm_pkg::IDX_W'(MAX_PATTERN);

  logic                      load_open_r, load_open_nxt;
  logic                      fold_r, fold_nxt;
  logic [gpm_pkg::IDX_W-1:0] len_r, len_nxt;
  logic                      in_class_r, in_class_nxt;
  logic                      esc_r, esc_nxt;
  logic                      dash_r, dash_nxt;
  logic                      err_r, err_nxt;
  logic                      jo_r, jo_nxt;
  logic                      ps_r, ps_nxt;

  logic                      start;
  logic                      fold_e;
  logic [gpm_pkg::IDX_W-1:0] len_e;
  logic                      in_class_e, esc_e, dash_e, err_e, jo_e, ps_e;
  logic [7:0]                f;

  assign start      = !load_open_r;
  assign fold_e     = start ? !match_case : fold_r;
  assign len_e      = start ? '0 : len_r;
  assign in_class_e = start ? 1'b0 : in_class_r;
  assign esc_e      = start ? 1'b0 : esc_r;
  assign dash_e     = start ? 1'b0 : dash_r;
  assign err_e      = start ? 1'b0 : err_r;
  assign jo_e       = start ? 1'b0 : jo_r;
  assign ps_e       = start ? 1'b0 : ps_r;
  assign f          = gpm_pkg::fold_char(in_word.char_value, fold_e);

  always_comb begin
    gpm_pkg::gpm_role_t role;
    logic               fix;
    role          = gpm_pkg::ROLE_LIT;
    fix           = 1'b0;
    wr            = '0;
    load_open_nxt = load_open_r;
    fold_nxt      = fold_r;
    len_nxt       = len_r;
    in_class_nxt  = in_class_r;
    esc_nxt       = esc_r;
    dash_nxt      = dash_r;
    err_nxt       = err_r;
    jo_nxt        = jo_r;
    ps_nxt        = ps_r;
    if (acc) begin
      load_open_nxt = 1'b1;
      fold_nxt      = fold_e;
      len_nxt       = len_e;
      in_class_nxt  = in_class_e;
      esc_nxt       = esc_e;
      dash_nxt      = dash_e;
      err_nxt       = err_e;
      jo_nxt        = jo_e;
      ps_nxt        = ps_e;
      if (!in_word.is_empty) begin
        jo_nxt = 1'b0;
        if (esc_e) begin
          esc_nxt = 1'b0;
          role    = in_class_e ? gpm_pkg::ROLE_SINGLE : gpm_pkg::ROLE_ESCD;
          ps_nxt  = in_class_e;
        end else if (dash_e) begin
          dash_nxt = 1'b0;
          role     = gpm_pkg::ROLE_HI;
          ps_nxt   = 1'b0;
          if (f == gpm_pkg::CH_RBR) err_nxt = 1'b1;
        end else if (f == gpm_pkg::CH_BSL) begin
          esc_nxt = 1'b1;
          role    = in_class_e ? gpm_pkg::ROLE_ESCB : gpm_pkg::ROLE_ESC;
          ps_nxt  = 1'b0;
        end else if (in_class_e && f == gpm_pkg::CH_DASH) begin
          dash_nxt = 1'b1;
          ps_nxt   = 1'b0;
          if (ps_e) begin
            role = gpm_pkg::ROLE_DASH;
            fix  = 1'b1;
          end else begin
            role = gpm_pkg::ROLE_LO;
          end
        end else if (f == gpm_pkg::CH_LBR && !in_class_e) begin
          in_class_nxt = 1'b1;
          jo_nxt       = 1'b1;
          role         = gpm_pkg::ROLE_OPEN;
          ps_nxt       = 1'b0;
        end else if (f == gpm_pkg::CH_RBR && in_class_e) begin
          in_class_nxt = 1'b0;
          role         = gpm_pkg::ROLE_CLOSE;
          ps_nxt       = 1'b0;
        end else if (in_class_e) begin
          if (jo_e && f == gpm_pkg::CH_CARET) begin
            role   = gpm_pkg::ROLE_NEG;
            ps_nxt = 1'b0;
          end else begin
            role   = gpm_pkg::ROLE_SINGLE;
            ps_nxt = 1'b1;
          end
        end else if (f == gpm_pkg::CH_STAR) begin
          role = gpm_pkg::ROLE_STAR;
        end else if (f == gpm_pkg::CH_QUEST) begin
          role = gpm_pkg::ROLE_ANY;
        end else begin
          role = gpm_pkg::ROLE_LIT;
        end
        if (len_e < MAXV) begin
          wr.we    = 1'b1;
          wr.widx  = len_e;
          wr.wchar = f;
          wr.wrole = role;
          wr.fe    = fix && (len_e != '0);
          wr.fidx  = len_e - gpm_pkg::IDX_W'(1);
          len_nxt  = len_e + gpm_pkg::IDX_W'(1);
        end else begin
          err_nxt = 1'b1;
        end
      end
      if (in_word.last) begin
        if (esc_nxt || dash_nxt || in_class_nxt) err_nxt = 1'b1;
        load_open_nxt = 1'b0;
        wr.clr        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_open_r <= 1'b0;
      fold_r      <= 1'b0;
      len_r       <= '0;
      in_class_r  <= 1'b0;
      esc_r       <= 1'b0;
      dash_r      <= 1'b0;
      err_r       <= 1'b0;
      jo_r        <= 1'b0;
      ps_r        <= 1'b0;
    end else begin
      load_open_r <= load_open_nxt;
      fold_r      <= fold_nxt;
      len_r       <= len_nxt;
      in_class_r  <= in_class_nxt;
      esc_r       <= esc_nxt;
      dash_r      <= dash_nxt;
      err_r       <= err_nxt;
      jo_r        <= jo_nxt;
      ps_r        <= ps_nxt;
    end
  end

  assign len       = len_r;
  assign err_flag  = err_r;
  assign err_final = err_nxt;
  assign fold      = fold_r;
  assign load_open = load_open_r;

endmodule

### hdl/glob_pattern_matcher.sv
// ----------------------------------------------------------------------------
// Glob pattern matcher
// Loads a glob pattern into a row of cells and matches text words against it.
//
//   channel   dir   handshake          payload
//   in_       in    in_valid/in_stall  gpm_in_t   (pattern or text word)
//   out_      out   out_valid/out_stall gpm_out_t (one per closing word)
//   cfg_      in    cfg_valid/cfg_ready match_case bit
//
// One text word enters the cell row per cycle unless the row is frozen; its
// wave crosses one cell per cycle as the row advances. A pattern word waits
// until no text wave is left in the row; its result follows in the cycle
// after acceptance. out_stall freezes the whole row while out_valid is high.
// Reset is synchronous and leaves an empty pattern and match_case at 1.
// ----------------------------------------------------------------------------
`include "glob_pattern_matcher_assert.svh"

module glob_pattern_matcher #(
  parameter int MAX_PATTERN = 63
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  gpm_pkg::gpm_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output gpm_pkg::gpm_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);

  localparam int NCELL = MAX_PATTERN + 1;
  localparam int CNT_W = $clog2(NCELL + 2);

  logic                      match_case_r;
  logic                      adv;
  logic                      in_is_pat;
  logic                      acc;
  logic                      text_enter;
  logic                      pat_res;
  logic                      exit_res;
  logic                      exit_vld;
  logic [CNT_W-1:0]          inflight_r, inflight_nxt;
  logic                      out_valid_r;
  gpm_pkg::gpm_out_t         out_data_r;
  gpm_pkg::gpm_wr_t          wr;
  logic [gpm_pkg::IDX_W-1:0] len;
  logic                      err_flag;
  logic                      err_final;
  logic                      fold;
  logic                      load_open;
  gpm_pkg::gpm_wave_t        wave_in;
  gpm_pkg::gpm_wave_t        wave [0:NCELL];

  assign adv        = !(out_valid_r && out_stall);
  assign in_is_pat  = (in_data.func == gpm_pkg::FUNC_PATTERN);
  assign in_stall   = !adv || (in_is_pat && inflight_r != '0);
  assign acc        = in_valid && !in_stall;
  assign text_enter = acc && !in_is_pat && !load_open;
  assign pat_res    = acc && in_is_pat && in_data.last;
  assign exit_vld   = wave[NCELL].vld;
  assign exit_res   = exit_vld && wave[NCELL].last;
  assign cfg_ready  = 1'b1;

  gpm_loader #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_loader (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc && in_is_pat),
    .in_word    (in_data),
    .match_case (match_case_r),
    .wr         (wr),
    .len        (len),
    .err_flag   (err_flag),
    .err_final  (err_final),
    .fold       (fold),
    .load_open  (load_open)
  );

  always_comb begin
    wave_in        = '0;
    wave_in.vld    = text_enter;
    wave_in.ch     = gpm_pkg::fold_char(in_data.char_value, fold);
    wave_in.has_ch = !in_data.is_empty;
    wave_in.last   = in_data.last;
  end

  assign wave[0] = wave_in;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    gpm_cell #(
      .IDX (i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .wr     (wr),
      .len    (len),
      .wave_i (wave[i]),
      .wave_o (wave[i+1])
    );
  end

  always_comb begin
    inflight_nxt = inflight_r;
    if (adv) begin
      inflight_nxt = inflight_r + CNT_W'(text_enter) - CNT_W'(exit_vld);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_case_r <= 1'b1;
      inflight_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) match_case_r <= cfg_data;
      inflight_r <= inflight_nxt;
      if (adv) out_valid_r <= exit_res || pat_res;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (pat_res) begin
        out_data_r.match         <= 1'b0;
        out_data_r.pattern_error <= err_final;
        out_data_r.for_pattern   <= 1'b1;
      end else begin
        out_data_r.match         <= wave[NCELL].mt && !err_flag;
        out_data_r.pattern_error <= err_flag;
        out_data_r.for_pattern   <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `GPM_ASSERT_IMP(a_pat_idle, acc && in_is_pat, inflight_r == '0)
  `GPM_ASSERT_IMP(a_exit_closed, exit_vld, !load_open)
  `GPM_ASSERT_IMP(a_no_collide, pat_res, !exit_vld)
  `GPM_ASSERT_IMP(a_bound, 1'b1, inflight_r <= CNT_W'(NCELL))
  `GPM_ASSERT_NXT(a_track, text_enter, inflight_r != '0)

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glob pattern matcher testbench
// Loads glob patterns and matches text strings against them, word by word.
// A local predictor of the matcher gives every result, and each result is
// compared with the oldest prediction. The stimulus is a directed set of
// special patterns, then random patterns and texts under three idle mixes,
// then a long receiver hold-off that fills the block.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int          PAT_MAX   = 63;
  localparam logic        FUNC_TEXT = 1'b1;
  localparam int          DRAIN_CYC = PAT_MAX + 20;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  gpm_pkg::gpm_in_t  in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  gpm_pkg::gpm_out_t out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_data = 1'b0;

  glob_pattern_matcher #(.MAX_PATTERN(PAT_MAX)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [7:0]  pat_mem [0:63];
  int unsigned pat_len = 0;
  logic [63:0] live_pos = 64'd1;
  bit          class_open = 0, esc_wait = 0, dash_wait = 0, pat_bad = 0;
  bit          loading = 0, fold_on = 0, case_exact = 1;

  gpm_pkg::gpm_out_t result_q [$];
  int          send_idle = 0, recv_idle = 0;
  int          hold_req = 0;
  int          word_cnt = 0;
  int          fail_cnt = 0;

  function automatic logic [7:0] fold_up(input logic [7:0] c);
    if (fold_on && c >= "a" && c <= "z") return c - 8'd32;
    return c;
  endfunction

  function automatic bit class_match(input int unsigned p, input logic [7:0] c,
                                     output int unsigned nxt);
    int unsigned i;
    logic [7:0]  x, lo, hi;
    bit          neg, any;
    i = p + 1; neg = 0; any = 0;
    if (i < pat_len && pat_mem[i] == gpm_pkg::CH_CARET) begin
      neg = 1; i++;
    end
    while (i < pat_len) begin
      x = pat_mem[i];
      if (x == gpm_pkg::CH_RBR) begin
        nxt = i + 1;
        return neg ? !any : any;
      end
      if (x == gpm_pkg::CH_DASH) begin
        if (i + 1 >= pat_len) break;
        lo = gpm_pkg::CH_DASH; hi = pat_mem[i+1]; i += 2;
      end else begin
        if (x == gpm_pkg::CH_BSL) begin
          if (i + 1 >= pat_len) break;
          lo = pat_mem[i+1]; i += 2;
        end else begin
          lo = x; i++;
        end
        hi = lo;
        if (i < pat_len && pat_mem[i] == gpm_pkg::CH_DASH) begin
          if (i + 1 >= pat_len) break;
          hi = pat_mem[i+1]; i += 2;
        end
      end
      if (c >= lo && c <= hi) any = 1;
    end
    nxt = pat_len;
    return 0;
  endfunction

  function automatic bit token_match(input int unsigned p, input logic [7:0] c,
                                     output int unsigned nxt);
    logic [7:0] x;
    x = pat_mem[p];
    if (x == gpm_pkg::CH_BSL) begin
      if (p + 1 >= pat_len) begin
        nxt = pat_len;
        return 0;
      end
      nxt = p + 2;
      return pat_mem[p+1] == c;
    end
    if (x == gpm_pkg::CH_LBR) return class_match(p, c, nxt);
    nxt = p + 1;
    return x == gpm_pkg::CH_QUEST || x == c;
  endfunction

  function automatic logic [63:0] star_fill(input logic [63:0] a);
    for (int p = 0; p < pat_len; p++)
      if (a[p] && pat_mem[p] == gpm_pkg::CH_STAR) a[p+1] = 1'b1;
    return a;
  endfunction

  function automatic logic [63:0] step_pos(input logic [63:0] a, input logic [7:0] c);
    logic [63:0] n;
    int unsigned q;
    n = '0;
    for (int p = 0; p < pat_len; p++) begin
      if (!a[p]) continue;
      if (pat_mem[p] == gpm_pkg::CH_STAR) n[p] = 1'b1;
      else if (token_match(p, c, q)) n[q] = 1'b1;
    end
    return n;
  endfunction

  task automatic predict_word(input gpm_pkg::gpm_in_t w);
    logic [7:0]        f;
    logic [63:0]       a;
    gpm_pkg::gpm_out_t r;
    if (w.func == gpm_pkg::FUNC_PATTERN) begin
      if (!loading) begin
        loading = 1; fold_on = !case_exact; pat_len = 0;
        class_open = 0; esc_wait = 0; dash_wait = 0; pat_bad = 0;
      end
      if (!w.is_empty) begin
        f = fold_up(w.char_value);
        if (pat_len < PAT_MAX) begin
          pat_mem[pat_len] = f; pat_len++;
        end else pat_bad = 1;
        if (esc_wait) esc_wait = 0;
        else if (dash_wait) begin
          dash_wait = 0;
          if (f == gpm_pkg::CH_RBR) pat_bad = 1;
        end
        else if (f == gpm_pkg::CH_BSL) esc_wait = 1;
        else if (class_open && f == gpm_pkg::CH_DASH) dash_wait = 1;
        else if (f == gpm_pkg::CH_LBR) class_open = 1;
        else if (f == gpm_pkg::CH_RBR && class_open) class_open = 0;
      end
      if (!w.last) return;
      if (esc_wait || dash_wait || class_open) pat_bad = 1;
      loading = 0; live_pos = 64'd1;
      r.match = 0; r.pattern_error = pat_bad; r.for_pattern = 1;
      result_q.push_back(r);
      return;
    end
    if (loading) return;
    if (!w.is_empty) live_pos = step_pos(star_fill(live_pos), fold_up(w.char_value));
    if (!w.last) return;
    a = star_fill(live_pos);
    r.match = a[pat_len] && !pat_bad;
    r.pattern_error = pat_bad;
    r.for_pattern = 0;
    live_pos = 64'd1;
    result_q.push_back(r);
  endtask

  task automatic send_word(input gpm_pkg::gpm_in_t w);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    predict_word(w);
    word_cnt++;
  endtask

  task automatic send_str(input logic func, input string s, input bit empty_tail);
    gpm_pkg::gpm_in_t w;
    int n;
    n = s.len();
    for (int i = 0; i < n; i++) begin
      w.func = func; w.char_value = s[i]; w.is_empty = 0;
      w.last = (i == n - 1) && !empty_tail;
      send_word(w);
    end
    if (n == 0 || empty_tail) begin
      w.func = func; w.char_value = 8'($urandom_range(255)); w.is_empty = 1; w.last = 1;
      send_word(w);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_case(input bit v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case_exact = v;
  endtask

  function automatic logic [7:0] pat_char();
    case ($urandom_range(15))
      0, 1:    return 8'("a" + $urandom_range(2));
      2, 3:    return 8'("A" + $urandom_range(2));
      4:       return gpm_pkg::CH_STAR;
      5:       return gpm_pkg::CH_QUEST;
      6:       return gpm_pkg::CH_LBR;
      7:       return gpm_pkg::CH_RBR;
      8:       return gpm_pkg::CH_DASH;
      9:       return gpm_pkg::CH_CARET;
      10:      return gpm_pkg::CH_BSL;
      11:      return 8'($urandom_range(255));
      default: return 8'("a" + $urandom_range(3));
    endcase
  endfunction

  function automatic logic [7:0] text_char();
    case ($urandom_range(9))
      0:       return 8'($urandom_range(255));
      1:       return 8'("A" + $urandom_range(3));
      2:       return gpm_pkg::CH_DASH;
      3:       return gpm_pkg::CH_STAR;
      default: return 8'("a" + $urandom_range(3));
    endcase
  endfunction

  // random pattern with noise: stray text words and empty words mid-string
  task automatic send_rand_pattern();
    gpm_pkg::gpm_in_t w;
    int n;
    n = ($urandom_range(49) == 0) ? $urandom_range(60, 66) : $urandom_range(0, 8);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(19) == 0) begin
        w.func = FUNC_TEXT; w.char_value = 8'($urandom_range(255));
        w.is_empty = 1'($urandom_range(1)); w.last = 1'($urandom_range(1));
        send_word(w);
      end
      if ($urandom_range(19) == 0) begin
        w.func = gpm_pkg::FUNC_PATTERN; w.char_value = 8'($urandom_range(255));
        w.is_empty = 1; w.last = 0;
        send_word(w);
      end
      w.func = gpm_pkg::FUNC_PATTERN; w.char_value = pat_char(); w.is_empty = 0;
      w.last = (i == n - 1);
      send_word(w);
    end
    if (n == 0) begin
      w.func = gpm_pkg::FUNC_PATTERN; w.char_value = 8'($urandom_range(255));
      w.is_empty = 1; w.last = 1;
      send_word(w);
    end
  endtask

  task automatic send_rand_text();
    gpm_pkg::gpm_in_t w;
    int n;
    n = $urandom_range(0, 10);
    for (int i = 0; i < n; i++) begin
      w.func = FUNC_TEXT; w.char_value = text_char();
      w.is_empty = ($urandom_range(14) == 0);
      w.last = (i == n - 1);
      send_word(w);
    end
    if (n == 0) begin
      w.func = FUNC_TEXT; w.char_value = 8'($urandom_range(255)); w.is_empty = 1; w.last = 1;
      send_word(w);
    end
  endtask

  task automatic test_directed();
    send_str(FUNC_TEXT, "", 1);
    send_str(gpm_pkg::FUNC_PATTERN, "\\", 0);
    send_str(FUNC_TEXT, "a", 0);
    send_str(gpm_pkg::FUNC_PATTERN, "[a-]", 0);
    send_str(gpm_pkg::FUNC_PATTERN, "[b", 0);
    send_str(gpm_pkg::FUNC_PATTERN, "*", 1);
    send_str(FUNC_TEXT, "", 1);
    send_str(gpm_pkg::FUNC_PATTERN, {"[^a-cx-z]?\\*", 8'hFF}, 0);
    send_str(FUNC_TEXT, {"d", 8'h00, "*", 8'hFF}, 0);
    drain();
    write_case(1'b0);
    send_str(gpm_pkg::FUNC_PATTERN, "a[]*", 0);
    send_str(FUNC_TEXT, "A", 0);
    drain();
    write_case(1'b1);
  endtask

  task automatic test_random(input int s_idle, input int r_idle, input int words);
    int stop;
    send_idle = s_idle;
    recv_idle = r_idle;
    stop = word_cnt + words;
    while (word_cnt < stop) begin
      if ($urandom_range(5) == 0) begin
        drain();
        write_case(1'($urandom_range(1)));
      end
      send_rand_pattern();
      repeat ($urandom_range(1, 5)) send_rand_text();
    end
    drain();
  endtask

  task automatic test_hold_off();
    send_idle = 0;
    recv_idle = 0;
    send_str(gpm_pkg::FUNC_PATTERN, "*a?[b-d]*", 0);
    hold_req++;
    repeat (30) send_rand_text();
    drain();
  endtask

  // result checker and receiver stall
  int hold_seen = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    gpm_pkg::gpm_out_t exp_r;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) $display("unexpected result word %b", out_data);
        end else begin
          exp_r = result_q.pop_front();
          if (out_data !== exp_r) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("result mismatch: exp match=%b err=%b pat=%b got %b %b %b",
                       exp_r.match, exp_r.pattern_error, exp_r.for_pattern,
                       out_data.match, out_data.pattern_error, out_data.for_pattern);
          end
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(13, 81, 100);
    test_random(81, 13, 100);
    test_random(0, 0, 100);
    test_hold_off();
    if (fail_cnt == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule
